// File: rtl/sio_pkg.sv
// shared types, register codes and the device entry update function for the
// super i/o configuration register file; no dependencies
package sio_pkg;

  localparam int NUM_DEVICES_DEF = 9;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CONFIG1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CONFIG2 = 2'd1;
  localparam logic [7:0] CONFIG1_RESET = 8'h04;
  localparam logic [7:0] CONFIG2_RESET = 8'h03;

  // register indexes behind the data port
  localparam logic [7:0] REG_DEVSEL = 8'h07;
  localparam logic [7:0] REG_CHIPID = 8'h20;
  localparam logic [7:0] REG_CFG1   = 8'h21;
  localparam logic [7:0] REG_CFG2   = 8'h22;
  localparam logic [7:0] REG_EN     = 8'h30;
  localparam logic [7:0] REG_AHI    = 8'h60;
  localparam logic [7:0] REG_ALO    = 8'h61;
  localparam logic [7:0] REG_IRQ    = 8'h70;
  localparam logic [7:0] REG_DMA    = 8'h74;

  localparam logic [7:0] CHIP_ID    = 8'h20;
  localparam logic [7:0] READ_NONE  = 8'hff;
  localparam logic [3:0] DEVSEL_MASK = 4'hf;

  // access kinds and ports
  localparam logic OP_READ   = 1'b0;
  localparam logic OP_WRITE  = 1'b1;
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  // logical devices that report reconfigure events
  localparam logic [3:0] DEV_FLOPPY  = 4'd3;
  localparam logic [3:0] DEV_PARPORT = 4'd4;
  localparam logic [3:0] DEV_SERIAL2 = 4'd5;
  localparam logic [3:0] DEV_SERIAL1 = 4'd6;

  localparam logic [1:0] RCFG_FLOPPY  = 2'd0;
  localparam logic [1:0] RCFG_PARPORT = 2'd1;
  localparam logic [1:0] RCFG_SERIAL2 = 2'd2;
  localparam logic [1:0] RCFG_SERIAL1 = 2'd3;

  typedef struct packed {
    logic       operation;
    logic       port_select;
    logic [7:0] write_data;
  } sio_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        reconfig_valid;
    logic [1:0]  reconfig_device;
    logic        reconfig_enabled;
    logic [15:0] reconfig_address;
    logic [7:0]  reconfig_irq;
  } sio_out_t;

  typedef struct packed {
    logic [7:0]  enable;
    logic [15:0] address;
    logic [7:0]  irq;
    logic [7:0]  dma;
  } sio_entry_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] reg_index;
    logic [7:0] data;
  } sio_dev_wr_t;

  // new value of a device entry after a data write to register idx
  function automatic sio_entry_t entry_update(sio_entry_t ent, logic [7:0] idx,
                                              logic [7:0] v);
    sio_entry_t r;
    r = ent;
    case (idx)
      REG_EN:  r.enable = v;
      REG_ALO: r.address[7:0] = v;
      REG_AHI: r.address[15:8] = v;
      REG_IRQ: r.irq = v;
      REG_DMA: r.dma = v;
      default: r = ent;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/superio_config_register_file_top.sv
// super i/o index/data configuration port: input register, decode, result register
// depends on sio_pkg, sio_cfg_regs, sio_dev_table
// the result strobe (done) is registered with the result, behind the input register
// throughput: one item per cycle; busy stays low, the input and result registers pipeline
// each access and all state updates at the edge that loads the result register
// reset: synchronous, clears index, device select and all device entries, loads config reset values
// in the same cycle; the receiver cannot stall results
module superio_config_register_file_top #(
  parameter int NUM_DEVICES = sio_pkg::NUM_DEVICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  sio_pkg::sio_in_t              cmd,
  output logic                          done,
  output sio_pkg::sio_out_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sio_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import sio_pkg::*;

  logic        in_valid;
  sio_in_t     in_item;
  logic [7:0]  reg_index;
  logic [7:0]  reg_index_next;
  logic [3:0]  selected_device;
  logic [3:0]  selected_device_next;
  logic [7:0]  config1;
  logic [7:0]  config2;
  sio_dev_wr_t dev_wr;
  sio_entry_t  dev_rd;
  sio_entry_t  dev_new;
  logic        dev_ok;
  sio_out_t    res_next;
  logic        is_data_write;

  assign busy = 1'b0;

  sio_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .config1   (config1),
    .config2   (config2)
  );

  sio_dev_table #(.NUM_DEVICES(NUM_DEVICES)) u_dev (
    .clk (clk),
    .rst (rst),
    .sel (selected_device),
    .wr  (dev_wr),
    .rd  (dev_rd),
    .ok  (dev_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_item <= cmd;
    end
  end

  // data write that is not a device select
  assign is_data_write = in_valid && (in_item.operation == OP_WRITE) &&
                         (in_item.port_select == PORT_DATA) && (reg_index != REG_DEVSEL);

  assign dev_wr.valid     = is_data_write;
  assign dev_wr.reg_index = reg_index;
  assign dev_wr.data      = in_item.write_data;

  always_comb begin
    dev_new = '0;
    if (dev_ok) begin
      dev_new = entry_update(dev_rd, reg_index, in_item.write_data);
    end
  end

  always_comb begin
    reg_index_next       = reg_index;
    selected_device_next = selected_device;
    res_next             = '0;
    res_next.read_data   = READ_NONE;
    if (in_valid) begin
      if (in_item.operation == OP_READ) begin
        case (reg_index)
          REG_DEVSEL: res_next.read_data = {4'b0, selected_device};
          REG_CHIPID: res_next.read_data = CHIP_ID;
          REG_CFG1:   res_next.read_data = config1;
          REG_CFG2:   res_next.read_data = config2;
          REG_EN:     res_next.read_data = dev_ok ? dev_rd.enable : READ_NONE;
          REG_ALO:    res_next.read_data = dev_ok ? dev_rd.address[7:0] : READ_NONE;
          REG_AHI:    res_next.read_data = dev_ok ? dev_rd.address[15:8] : READ_NONE;
          REG_IRQ:    res_next.read_data = dev_ok ? dev_rd.irq : READ_NONE;
          REG_DMA:    res_next.read_data = dev_ok ? dev_rd.dma : READ_NONE;
          default:    res_next.read_data = READ_NONE;
        endcase
      end else if (in_item.port_select == PORT_INDEX) begin
        reg_index_next = in_item.write_data;
      end else if (reg_index == REG_DEVSEL) begin
        selected_device_next = in_item.write_data[3:0] & DEVSEL_MASK;
      end else begin
        res_next.reconfig_valid = 1'b1;
        case (selected_device)
          DEV_FLOPPY:  res_next.reconfig_device = RCFG_FLOPPY;
          DEV_PARPORT: res_next.reconfig_device = RCFG_PARPORT;
          DEV_SERIAL2: res_next.reconfig_device = RCFG_SERIAL2;
          DEV_SERIAL1: res_next.reconfig_device = RCFG_SERIAL1;
          default:     res_next.reconfig_valid  = 1'b0;
        endcase
        if (res_next.reconfig_valid) begin
          res_next.reconfig_enabled = dev_new.enable[0];
          res_next.reconfig_address = dev_new.address;
          res_next.reconfig_irq     = dev_new.irq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_index       <= '0;
      selected_device <= '0;
      done            <= 1'b0;
    end else begin
      reg_index       <= reg_index_next;
      selected_device <= selected_device_next;
      done            <= in_valid;
    end
    if (in_valid) begin
      result <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_follows_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("result strobe without an item in the input register");

  a_read_no_reconfig: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_item.operation == OP_READ) |=> (done && !result.reconfig_valid))
    else $error("read access reported a reconfigure event");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.reconfig_valid) |->
      (result.reconfig_address == 16'h0 && result.reconfig_irq == 8'h0 &&
       !result.reconfig_enabled && result.reconfig_device == 2'd0))
    else $error("reconfigure fields not cleared without an event");

  a_devsel_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_item.operation == OP_WRITE && in_item.port_select == PORT_DATA &&
      reg_index == REG_DEVSEL) |=> $stable(selected_device))
    else $error("device select changed without a device select write");
`endif

endmodule

// File: rtl/sio_cfg_regs.sv
// global configuration registers written over the configuration channel
// depends on sio_pkg
module sio_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sio_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output logic [7:0]                    config1,
  output logic [7:0]                    config2
);
  import sio_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      config1 <= CONFIG1_RESET;
      config2 <= CONFIG2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_CONFIG1: config1 <= cfg_data;
        CFG_IDX_CONFIG2: config2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/sio_dev_table.sv
// per logical device entries (enable, address, irq, dma) in flip-flops
// depends on sio_pkg
module sio_dev_table #(
  parameter int NUM_DEVICES = sio_pkg::NUM_DEVICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [3:0]           sel,
  input  sio_pkg::sio_dev_wr_t wr,
  output sio_pkg::sio_entry_t  rd,
  output logic                 ok
);
  import sio_pkg::*;

  localparam int DEV_AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

  sio_entry_t          ent [NUM_DEVICES];
  logic [DEV_AW-1:0]   idx;

  assign ok  = {1'b0, sel} < 5'(NUM_DEVICES);
  assign idx = DEV_AW'(sel);

  always_comb begin
    rd = '0;
    if (ok) begin
      rd = ent[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DEVICES; i++) begin
        ent[i] <= '0;
      end
    end else if (wr.valid && ok) begin
      ent[idx] <= entry_update(ent[idx], wr.reg_index, wr.data);
    end
  end

endmodule

// File: sim/superio_config_register_file_top_test.sv
// self-checking testbench for the super i/o index/data configuration port
// depends on sio_pkg and superio_config_register_file_top; predicts every access result
module superio_config_register_file_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sio_pkg::*;

  localparam int NDEV = NUM_DEVICES_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 430;

  // predicts the result of each accepted access and checks the block's results in order
  class access_tracker;
    sio_out_t expected_q[$];
    int errors;
    logic [7:0] cfg1;
    logic [7:0] cfg2;
    logic [7:0] reg_index;
    logic [3:0] sel_dev;
    sio_entry_t entries[NDEV];

    function new();
      errors = 0;
      cfg1 = CONFIG1_RESET;
      cfg2 = CONFIG2_RESET;
      reg_index = '0;
      sel_dev = '0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function void write_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
      if (idx == CFG_IDX_CONFIG1) cfg1 = d;
      else if (idx == CFG_IDX_CONFIG2) cfg2 = d;
    endfunction

    function void note_access(sio_in_t c);
      sio_out_t e;
      logic ok;
      logic hit;
      logic [1:0] code;
      e = '0;
      e.read_data = READ_NONE;
      ok = ({1'b0, sel_dev} < 5'(NDEV));
      hit = 1'b1;
      code = RCFG_FLOPPY;
      if (c.operation == OP_READ) begin
        case (reg_index)
          REG_DEVSEL: e.read_data = {4'h0, sel_dev};
          REG_CHIPID: e.read_data = CHIP_ID;
          REG_CFG1:   e.read_data = cfg1;
          REG_CFG2:   e.read_data = cfg2;
          REG_EN:     if (ok) e.read_data = entries[sel_dev].enable;
          REG_ALO:    if (ok) e.read_data = entries[sel_dev].address[7:0];
          REG_AHI:    if (ok) e.read_data = entries[sel_dev].address[15:8];
          REG_IRQ:    if (ok) e.read_data = entries[sel_dev].irq;
          REG_DMA:    if (ok) e.read_data = entries[sel_dev].dma;
          default:    e.read_data = READ_NONE;
        endcase
      end else if (c.port_select == PORT_INDEX) begin
        reg_index = c.write_data;
      end else if (reg_index == REG_DEVSEL) begin
        sel_dev = c.write_data[3:0] & DEVSEL_MASK;
      end else begin
        if (ok) begin
          case (reg_index)
            REG_EN:  entries[sel_dev].enable = c.write_data;
            REG_ALO: entries[sel_dev].address[7:0] = c.write_data;
            REG_AHI: entries[sel_dev].address[15:8] = c.write_data;
            REG_IRQ: entries[sel_dev].irq = c.write_data;
            REG_DMA: entries[sel_dev].dma = c.write_data;
            default: ;
          endcase
        end
        case (sel_dev)
          DEV_FLOPPY:  code = RCFG_FLOPPY;
          DEV_PARPORT: code = RCFG_PARPORT;
          DEV_SERIAL2: code = RCFG_SERIAL2;
          DEV_SERIAL1: code = RCFG_SERIAL1;
          default:     hit = 1'b0;
        endcase
        // every non-select data write to one of the four event devices reports the event, even to unknown registers
        if (hit) begin
          e.reconfig_valid = 1'b1;
          e.reconfig_device = code;
          if (ok) begin
            e.reconfig_enabled = entries[sel_dev].enable[0];
            e.reconfig_address = entries[sel_dev].address;
            e.reconfig_irq = entries[sel_dev].irq;
          end
        end
      end
      expected_q.push_back(e);
    endfunction

    function void report(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_reply(sio_out_t got);
      sio_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      report("read_data", 16'(e.read_data), 16'(got.read_data));
      report("reconfig_valid", 16'(e.reconfig_valid), 16'(got.reconfig_valid));
      report("reconfig_device", 16'(e.reconfig_device), 16'(got.reconfig_device));
      report("reconfig_enabled", 16'(e.reconfig_enabled), 16'(got.reconfig_enabled));
      report("reconfig_address", e.reconfig_address, got.reconfig_address);
      report("reconfig_irq", 16'(e.reconfig_irq), 16'(got.reconfig_irq));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  sio_in_t cmd;
  logic done;
  sio_out_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  access_tracker tracker;

  superio_config_register_file_top #(.NUM_DEVICES(NDEV)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_config(cfg_index, cfg_data);
      if (start && !busy) tracker.note_access(cmd);
      if (done) tracker.check_reply(result);
    end
  end

  task automatic send(input logic op, input logic port, input logic [7:0] data,
                      input int idle_pct);
    sio_in_t c;
    c.operation = op;
    c.port_select = port;
    c.write_data = data;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_config(input logic [7:0] c1, input logic [7:0] c2,
                             input bit with_unused);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [7:0] val[3];
    int n;
    n = 0;
    if (with_unused) begin
      idx[n] = CFG_IDX_UNUSED;
      val[n] = 8'($urandom_range(255));
      n++;
    end
    idx[n] = CFG_IDX_CONFIG1;
    val[n] = c1;
    n++;
    idx[n] = CFG_IDX_CONFIG2;
    val[n] = c2;
    n++;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_register();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return REG_DEVSEL;
    if (roll < 24) return REG_CHIPID;
    if (roll < 29) return REG_CFG1;
    if (roll < 34) return REG_CFG2;
    if (roll < 44) return REG_EN;
    if (roll < 53) return REG_AHI;
    if (roll < 62) return REG_ALO;
    if (roll < 72) return REG_IRQ;
    if (roll < 82) return REG_DMA;
    return 8'($urandom_range(255));
  endfunction

  // mostly index-then-data sequences, some raw noise
  task automatic run_random(input int n_items, input int idle_pct);
    int count;
    int k;
    int roll;
    logic [7:0] r;
    logic [3:0] dev;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(99) < 15) begin
        send(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
             idle_pct);
        count++;
      end else begin
        r = pick_register();
        send(OP_WRITE, PORT_INDEX, r, idle_pct);
        count++;
        k = $urandom_range(1, 3);
        repeat (k) begin
          roll = $urandom_range(99);
          if (roll < 50) begin
            if (r == REG_DEVSEL) begin
              dev = ($urandom_range(99) < 80) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
              send(OP_WRITE, PORT_DATA, {4'($urandom_range(15)), dev}, idle_pct);
            end else begin
              send(OP_WRITE, PORT_DATA, 8'($urandom_range(255)), idle_pct);
            end
          end else if (roll < 85) begin
            send(OP_READ, PORT_DATA, 8'($urandom_range(255)), idle_pct);
          end else begin
            send(OP_READ, PORT_INDEX, 8'($urandom_range(255)), idle_pct);
          end
          count++;
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset values, chip id, config reads, device programming
    send(OP_READ, PORT_INDEX, 8'h00, 0);
    send(OP_WRITE, PORT_INDEX, REG_CHIPID, 0);
    send(OP_READ, PORT_DATA, 8'h00, 0);
    send(OP_READ, PORT_INDEX, 8'hff, 0);
    send(OP_WRITE, PORT_INDEX, REG_CFG1, 0);
    send(OP_WRITE, PORT_DATA, 8'h5a, 0);
    send(OP_READ, PORT_DATA, 8'h00, 0);
    send(OP_WRITE, PORT_INDEX, REG_CFG2, 0);
    send(OP_READ, PORT_INDEX, 8'h00, 0);
    send(OP_WRITE, PORT_INDEX, REG_DEVSEL, 0);
    send(OP_WRITE, PORT_DATA, 8'hf3, 0);
    send(OP_READ, PORT_DATA, 8'h00, 0);
    send(OP_WRITE, PORT_INDEX, REG_EN, 0);
    send(OP_WRITE, PORT_DATA, 8'hff, 0);
    send(OP_WRITE, PORT_INDEX, REG_AHI, 0);
    send(OP_WRITE, PORT_DATA, 8'hff, 0);
    send(OP_WRITE, PORT_INDEX, REG_ALO, 0);
    send(OP_WRITE, PORT_DATA, 8'h00, 0);
    send(OP_WRITE, PORT_INDEX, REG_IRQ, 0);
    send(OP_WRITE, PORT_DATA, 8'h0f, 0);
    // device above range: writes ignored, reads return 0xff
    send(OP_WRITE, PORT_INDEX, REG_DEVSEL, 0);
    send(OP_WRITE, PORT_DATA, 8'h0c, 0);
    send(OP_WRITE, PORT_INDEX, REG_EN, 0);
    send(OP_READ, PORT_DATA, 8'h00, 0);
    // unknown register write still reports the event
    send(OP_WRITE, PORT_INDEX, REG_DEVSEL, 0);
    send(OP_WRITE, PORT_DATA, 8'h06, 0);
    send(OP_WRITE, PORT_INDEX, 8'hff, 0);
    send(OP_WRITE, PORT_DATA, 8'h80, 0);
    drain();

    load_config(8'h00, 8'hff, 1'b0);
    run_random(ITEMS_PER_PHASE, 17);
    drain();

    load_config(8'hff, 8'h00, 1'b1);
    run_random(ITEMS_PER_PHASE, 81);
    drain();

    load_config(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
    run_random(ITEMS_PER_PHASE, 0);
    drain();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sio_pkg.sv
rtl/sio_cfg_regs.sv
rtl/sio_dev_table.sv
rtl/superio_config_register_file_top.sv
sim/superio_config_register_file_top_test.sv
